[hdl/tile_gid_source_rect_defines.svh]
// Assertion macros shared by the tile id lookup block.
`ifndef TILE_GID_SOURCE_RECT_DEFINES_SVH
`define TILE_GID_SOURCE_RECT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TGSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define TGSR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[hdl/tgsr_pkg.sv]
// Types and constants shared by the tile id lookup modules.
package tgsr_pkg;

    localparam int ID_W      = 24;
    localparam int DIM_W     = 10;
    localparam int COLS_W    = 12;
    localparam int ENTRY_W   = 56;
    localparam int SET_W     = 3;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int X_W       = 22;
    localparam int Y_W       = 34;

    localparam int FIRST_LSB  = 0;
    localparam int WIDTH_LSB  = 24;
    localparam int HEIGHT_LSB = 34;
    localparam int COLS_LSB   = 44;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_A = 3'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BELOW   = 2'd1,
        ST_NO_COLS = 2'd2
    } tgsr_status_t;

    // Classified request travelling from the front to the back.
    typedef struct packed {
        tgsr_status_t       status;
        logic [SET_W-1:0]   set_num;
        logic [ID_W-1:0]    local_idx;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COLS_W-1:0]  cols;
    } tgsr_item_t;

    // One stage of the restoring divider.
    typedef struct packed {
        tgsr_item_t         item;
        logic [COLS_W-1:0]  rem;
        logic [ID_W-1:0]    num;
    } tgsr_div_t;

    typedef struct packed {
        tgsr_status_t       status;
        logic [SET_W-1:0]   set_num;
        logic [ID_W-1:0]    local_idx;
        logic [X_W-1:0]     src_x;
        logic [Y_W-1:0]     src_y;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } tgsr_result_t;

endpackage

[hdl/tile_gid_source_rect.sv]
// Top level of the global tile id to atlas source rectangle lookup.
//
// Usage: software writes the tileset table over the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) while no request is in flight.
// Index 0 is the tileset count, indexes 1 to 7 the packed entries; cfg_ready
// is always high. A request is taken at a rising edge where start is high
// and busy is low; one request can enter every cycle while busy stays low.
// Each result appears on the result ports for one cycle with done high.
// From the accepting edge a request passes the match register, the queue,
// ID_BITS stages of the divider by the column count (one quotient bit per
// stage), and the output register that takes the origin multiplies.
// The receiver cannot stall, so the back end drains the queue every cycle
// and busy stays low in normal use.
// Reset clears the table to one tileset entry of all zeros and empties the
// pipeline; no result is produced for requests in flight at reset.
`include "tile_gid_source_rect_defines.svh"

module tile_gid_source_rect
    import tgsr_pkg::*;
#(
    parameter int MAX_TILESETS = 7,
    parameter int ID_BITS      = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ENTRY_W-1:0]   cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [ID_W-1:0]      global_id,
    output logic                 done,
    output logic [1:0]           status,
    output logic [SET_W-1:0]     set_number,
    output logic [ID_W-1:0]      local_index,
    output logic [X_W-1:0]       source_x,
    output logic [Y_W-1:0]       source_y,
    output logic [DIM_W-1:0]     rect_width,
    output logic [DIM_W-1:0]     rect_height
);

    localparam int LATENCY = ID_BITS + 3;

    logic         q_full;
    logic         fr_valid;
    tgsr_item_t   fr_item;
    logic         q_valid;
    tgsr_item_t   q_item;
    tgsr_result_t result;
    logic         err_out;
    logic         fields_zero;

    assign cfg_ready = 1'b1;

    tgsr_front #(
        .MAX_TILESETS (MAX_TILESETS),
        .ID_BITS      (ID_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .global_id  (global_id),
        .q_full     (q_full),
        .busy       (busy),
        .item_valid (fr_valid),
        .item       (fr_item)
    );

    tgsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_valid),
        .push_item  (fr_item),
        .pop        (1'b1),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_item)
    );

    tgsr_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .out_valid  (done),
        .out_result (result)
    );

    assign status      = result.status;
    assign set_number  = result.set_num;
    assign local_index = result.local_idx;
    assign source_x    = result.src_x;
    assign source_y    = result.src_y;
    assign rect_width  = result.width;
    assign rect_height = result.height;

    assign err_out     = done && (status != ST_OK);
    assign fields_zero = (set_number == '0) && (local_index == '0) && (source_x == '0)
                         && (source_y == '0) && (rect_width == '0) && (rect_height == '0);

    `TGSR_ASSERT_IMP(a_fixed_latency, start && !busy, ##LATENCY done, "result late")
    `TGSR_ASSERT_IMP(a_error_zero, err_out, fields_zero, "error result not cleared")
    `TGSR_ASSERT_NEVER(a_never_full, q_full, "queue filled although the back end drains it")

endmodule

[hdl/tgsr_front.sv]
// Front end: tileset table registers, request accept and tileset match.
module tgsr_front
    import tgsr_pkg::*;
#(
    parameter int MAX_TILESETS = 7,
    parameter int ID_BITS      = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ENTRY_W-1:0]   cfg_data,
    input  logic                 start,
    input  logic [ID_W-1:0]      global_id,
    input  logic                 q_full,
    output logic                 busy,
    output logic                 item_valid,
    output tgsr_item_t           item
);

    localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << ID_BITS) - 64'd1);

    logic [COUNT_W-1:0] count_reg;
    logic [ENTRY_W-1:0] entry_reg [MAX_TILESETS];
    logic               fr_valid_reg;
    tgsr_item_t         fr_item_reg;
    tgsr_item_t         item_next;
    logic               accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            for (int i = 0; i < MAX_TILESETS; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            if (cfg_index == CFG_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_TILESETS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(CFG_ENTRY_A) + i))
                begin
                    entry_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Every entry below the count is compared at once; the highest hit wins.
    // Entry numbers never reach MAX_TILESETS, so a larger count clamps itself.
    always_comb
    begin
        logic [ID_W-1:0]    gid_m;
        logic [ID_W-1:0]    first;
        logic [ENTRY_W-1:0] e_sel;
        logic [SET_W-1:0]   sel;
        logic               found;
        gid_m = global_id & ID_MASK;
        e_sel = '0;
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < MAX_TILESETS; i++)
        begin
            first = entry_reg[i][FIRST_LSB +: ID_W] & ID_MASK;
            if ((COUNT_W'(i) < count_reg) && (first <= gid_m))
            begin
                found = 1'b1;
                sel   = SET_W'(i);
                e_sel = entry_reg[i];
            end
        end
        first = e_sel[FIRST_LSB +: ID_W] & ID_MASK;
        item_next = '0;
        if (!found)
        begin
            item_next.status = ST_BELOW;
        end
        else if (e_sel[COLS_LSB +: COLS_W] == '0)
        begin
            item_next.status = ST_NO_COLS;
        end
        else
        begin
            item_next.status    = ST_OK;
            item_next.set_num   = sel;
            item_next.local_idx = gid_m - first;
            item_next.width     = e_sel[WIDTH_LSB +: DIM_W];
            item_next.height    = e_sel[HEIGHT_LSB +: DIM_W];
            item_next.cols      = e_sel[COLS_LSB +: COLS_W];
        end
    end

    assign busy   = fr_valid_reg && q_full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            fr_valid_reg <= 1'b1;
        end
        else if (!q_full)
        begin
            fr_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_item_reg <= item_next;
        end
    end

    assign item_valid = fr_valid_reg && !q_full;
    assign item       = fr_item_reg;

endmodule

[hdl/tgsr_queue.sv]
// Two-entry queue between the classifying front and the arithmetic back.
module tgsr_queue
    import tgsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tgsr_item_t push_item,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output tgsr_item_t head_item
);

    tgsr_item_t  slot_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;
    logic        do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_item  = slot_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

[hdl/tgsr_back.sv]
// Back end: pipelined divide by the column count, then the origin multiplies.
module tgsr_back
    import tgsr_pkg::*;
#(
    parameter int ID_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  tgsr_item_t   in_item,
    output logic         out_valid,
    output tgsr_result_t out_result
);

    tgsr_div_t    stg_in    [ID_BITS];
    tgsr_div_t    stg_next  [ID_BITS];
    tgsr_div_t    stg_reg   [ID_BITS];
    logic         vld_in    [ID_BITS];
    logic         vld_reg   [ID_BITS];
    tgsr_result_t result_next;
    tgsr_result_t result_reg;
    logic         done_reg;

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < ID_BITS; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            always_comb
            begin
                stg_in[k].item = in_item;
                stg_in[k].rem  = '0;
                stg_in[k].num  = in_item.local_idx;
                vld_in[k]      = in_valid;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                stg_in[k] = stg_reg[k-1];
                vld_in[k] = vld_reg[k-1];
            end
        end

        always_comb
        begin
            logic [COLS_W:0] trial;
            logic            qbit;
            trial = {stg_in[k].rem, stg_in[k].num[ID_BITS-1]};
            qbit  = (trial >= {1'b0, stg_in[k].item.cols});
            stg_next[k].item = stg_in[k].item;
            if (qbit)
            begin
                stg_next[k].rem = COLS_W'(trial - {1'b0, stg_in[k].item.cols});
            end
            else
            begin
                stg_next[k].rem = trial[COLS_W-1:0];
            end
            stg_next[k].num = {stg_in[k].num[ID_W-2:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            stg_reg[k] <= stg_next[k];
        end
    end

    // Error items carry zero width and height, so both products come out zero.
    always_comb
    begin
        tgsr_div_t       last;
        logic [ID_W-1:0] quot;
        last = stg_reg[ID_BITS-1];
        quot = ID_W'(last.num[ID_BITS-1:0]);
        result_next.status    = last.item.status;
        result_next.set_num   = last.item.set_num;
        result_next.local_idx = last.item.local_idx;
        result_next.src_x     = X_W'(last.item.width) * X_W'(last.rem);
        result_next.src_y     = Y_W'(last.item.height) * Y_W'(quot);
        result_next.width     = last.item.width;
        result_next.height    = last.item.height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[ID_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = done_reg;
    assign out_result = result_reg;

endmodule

[bench/tb_tile_gid_source_rect.sv]
// Self-checking testbench for the global tile id to atlas source rectangle lookup.
module tb_tile_gid_source_rect;
    timeunit 1ns;
    timeprecision 1ps;

    import tgsr_pkg::*;

    localparam int MAX_SETS       = 7;
    localparam int RESULT_LATENCY = 27;
    localparam int MAX_IDLE       = 13;
    localparam int RANDOM_IDS     = 1300;
    localparam int PRINT_LIMIT    = 50;

    typedef struct {
        logic [ID_W-1:0] gid;
        int unsigned     gap;
    } pending_gid_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ENTRY_W-1:0]   cfg_data  = '0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic [ID_W-1:0]      global_id = '0;
    logic                 done;
    logic [1:0]           status;
    logic [SET_W-1:0]     set_number;
    logic [ID_W-1:0]      local_index;
    logic [X_W-1:0]       source_x;
    logic [Y_W-1:0]       source_y;
    logic [DIM_W-1:0]     rect_width;
    logic [DIM_W-1:0]     rect_height;

    // Shadow of the tileset table as the block should hold it.
    logic [COUNT_W-1:0]   tbl_count;
    logic [ENTRY_W-1:0]   tbl_entry [MAX_SETS];

    pending_gid_t         gid_requests [$];
    tgsr_result_t         pending_rects [$];
    logic                 req_taken = 1'b0;
    int unsigned          cfg_writes_seen = 0;
    int unsigned          burst_left = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          results_checked = 0;
    int unsigned          ids_sent = 0;
    int unsigned          table_settings = 0;
    int unsigned          status_hits [3] = '{0, 0, 0};

    tile_gid_source_rect dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .global_id   (global_id),
        .done        (done),
        .status      (status),
        .set_number  (set_number),
        .local_index (local_index),
        .source_x    (source_x),
        .source_y    (source_y),
        .rect_width  (rect_width),
        .rect_height (rect_height)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [ENTRY_W-1:0] make_entry(int unsigned first_id, int unsigned w,
                                                      int unsigned h, int unsigned cols);
        return {COLS_W'(cols), DIM_W'(h), DIM_W'(w), ID_W'(first_id)};
    endfunction

    function automatic tgsr_result_t predict_source_rect(logic [ID_W-1:0] gid);
        tgsr_result_t      r;
        logic              found;
        int                sel;
        int                n;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   offset;
        longint unsigned   w64;
        longint unsigned   h64;
        longint unsigned   cols64;
        r = '0;
        found = 1'b0;
        sel = 0;
        n = (tbl_count > MAX_SETS) ? MAX_SETS : int'(tbl_count);
        // The highest-numbered valid entry at or below the id wins, sorted or not.
        for (int i = 0; i < MAX_SETS; i++)
        begin
            if (i < n && tbl_entry[i][FIRST_LSB +: ID_W] <= gid)
            begin
                found = 1'b1;
                sel = i;
            end
        end
        if (!found)
        begin
            r.status = ST_BELOW;
            return r;
        end
        cols64 = 64'(tbl_entry[sel][COLS_LSB +: COLS_W]);
        if (cols64 == 0)
        begin
            r.status = ST_NO_COLS;
            return r;
        end
        first_id = tbl_entry[sel][FIRST_LSB +: ID_W];
        w64 = 64'(tbl_entry[sel][WIDTH_LSB +: DIM_W]);
        h64 = 64'(tbl_entry[sel][HEIGHT_LSB +: DIM_W]);
        offset = gid - first_id;
        r.status = ST_OK;
        r.set_num = SET_W'(sel);
        r.local_idx = offset;
        r.src_x = X_W'(w64 * (longint'(offset) % cols64));
        r.src_y = Y_W'(h64 * (longint'(offset) / cols64));
        r.width = DIM_W'(w64);
        r.height = DIM_W'(h64);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] %s: got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Requests are queued with the idle cycles that come before each of them.
    task automatic queue_gid(input logic [ID_W-1:0] gid);
        pending_gid_t req;
        req.gid = gid;
        if (burst_left > 0)
        begin
            burst_left--;
            req.gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(8, 40);
            req.gap = 0;
        end
        else
            req.gap = $urandom_range(0, MAX_IDLE);
        gid_requests.insert(gid_requests.size(), req);
    endtask

    // Returns at a falling edge once every request has been sent and answered.
    task automatic drain_results();
        do @(posedge clk);
        while (!(gid_requests.size() == 0 && !start && pending_rects.size() == 0));
        @(negedge clk);
    endtask

    // Called at a falling edge; writes the count and the masked entries in random order.
    task automatic load_table(input logic [COUNT_W-1:0] cnt,
                              input logic [ENTRY_W-1:0] ents [MAX_SETS],
                              input logic [MAX_SETS-1:0] mask);
        int                 order [MAX_SETS+1];
        int                 j;
        int                 tmp;
        int unsigned        seen;
        logic [ENTRY_W-1:0] noise;
        for (int i = 0; i <= MAX_SETS; i++)
            order[i] = i;
        for (int i = MAX_SETS; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i <= MAX_SETS; i++)
        begin
            if (order[i] == 0 || mask[order[i] - 1])
            begin
                seen = cfg_writes_seen;
                // Bits above the count field must be ignored by the block.
                noise = ENTRY_W'({$urandom, $urandom});
                noise[COUNT_W-1:0] = cnt;
                cfg_valid <= 1'b1;
                cfg_index <= CFG_IDX_W'(order[i]);
                cfg_data <= (order[i] == 0) ? noise : ents[order[i] - 1];
                do @(negedge clk);
                while (cfg_writes_seen == seen);
            end
        end
        cfg_valid <= 1'b0;
        table_settings++;
    endtask

    always @(negedge clk)
    begin : drive_requests
        pending_gid_t req;
        if (!rst_n || (start && !req_taken))
        begin
            // The current request stays on the ports until the block takes it.
        end
        else if (gid_requests.size() == 0)
        begin
            start <= 1'b0;
            global_id <= ID_W'($urandom);
        end
        else if (gid_requests[0].gap != 0)
        begin
            gid_requests[0].gap = gid_requests[0].gap - 1;
            start <= 1'b0;
            global_id <= ID_W'($urandom);
        end
        else
        begin
            req = gid_requests.pop_front();
            start <= 1'b1;
            global_id <= req.gid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : track_and_check
        tgsr_result_t want;
        if (!rst_n)
        begin
            tbl_count = COUNT_W'(1);
            for (int i = 0; i < MAX_SETS; i++)
                tbl_entry[i] = '0;
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= start && !busy;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_COUNT)
                    tbl_count = cfg_data[COUNT_W-1:0];
                else if (int'(cfg_index) - int'(CFG_ENTRY_A) < MAX_SETS)
                    tbl_entry[int'(cfg_index) - int'(CFG_ENTRY_A)] = cfg_data;
                cfg_writes_seen++;
            end
            if (done)
            begin
                if (pending_rects.size() == 0)
                    report_mismatch("result with no request waiting", {62'd0, status}, '0);
                else
                begin
                    want = pending_rects.pop_front();
                    results_checked++;
                    status_hits[want.status]++;
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (set_number !== want.set_num)
                        report_mismatch("set_number", 64'(set_number), 64'(want.set_num));
                    if (local_index !== want.local_idx)
                        report_mismatch("local_index", 64'(local_index), 64'(want.local_idx));
                    if (source_x !== want.src_x)
                        report_mismatch("source_x", 64'(source_x), 64'(want.src_x));
                    if (source_y !== want.src_y)
                        report_mismatch("source_y", 64'(source_y), 64'(want.src_y));
                    if (rect_width !== want.width)
                        report_mismatch("rect_width", 64'(rect_width), 64'(want.width));
                    if (rect_height !== want.height)
                        report_mismatch("rect_height", 64'(rect_height), 64'(want.height));
                end
            end
            if (start && !busy)
            begin
                pending_rects.insert(pending_rects.size(), predict_source_rect(global_id));
                ids_sent++;
            end
        end
    end

    initial
    begin : run_test
        logic [ENTRY_W-1:0]  ents [MAX_SETS];
        logic [MAX_SETS-1:0] mask;
        logic [COUNT_W-1:0]  cnt;
        int unsigned         dir_ids [15];
        int unsigned         random_sent;
        int unsigned         step_max;
        int unsigned         prev;
        int unsigned         first_id;
        int unsigned         w;
        int unsigned         h;
        int unsigned         cols;
        int unsigned         rn;
        int unsigned         batch;
        int unsigned         k;
        int unsigned         span;
        int unsigned         gid;
        logic                unsorted;
        logic                first_phase;

        for (int i = 0; i < MAX_SETS; i++)
            ents[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset table: one entry with zero columns, so every id reports zero columns.
        queue_gid(24'h000000);
        queue_gid(24'hFFFFFF);
        drain_results();

        // A count of zero leaves no valid entry.
        load_table(COUNT_W'(0), ents, '0);
        queue_gid(24'h000000);
        queue_gid(24'h5A5A5A);
        queue_gid(24'hFFFFFF);
        drain_results();

        // Full sorted table with zero width, zero height, zero columns and maximal fields.
        ents[0] = make_entry(10, 16, 16, 8);
        ents[1] = make_entry(50, 1023, 1023, 4095);
        ents[2] = make_entry(100, 0, 5, 3);
        ents[3] = make_entry(500, 7, 0, 1);
        ents[4] = make_entry(1000, 5, 5, 0);
        ents[5] = make_entry(2000, 32, 32, 4095);
        ents[6] = make_entry(24'hFFFFFF, 1023, 1023, 4095);
        load_table(COUNT_W'(7), ents, '1);
        dir_ids = '{9, 10, 17, 18, 50, 99, 100, 101, 500, 1000, 1999, 2000,
                    2000 + 4095 * 3 + 7, 24'hFFFFFE, 24'hFFFFFF};
        foreach (dir_ids[i])
            queue_gid(ID_W'(dir_ids[i]));
        drain_results();

        // Unsorted entries with a duplicate first id: the later entry must win.
        ents[0] = make_entry(300, 9, 9, 2);
        ents[1] = make_entry(100, 4, 4, 3);
        ents[2] = make_entry(100, 2, 2, 5);
        load_table(COUNT_W'(3), ents, 7'h07);
        queue_gid(ID_W'(150));
        queue_gid(ID_W'(350));
        drain_results();

        // Largest origins along each axis.
        ents[0] = make_entry(0, 1023, 1023, 1);
        ents[1] = make_entry(24'h800000, 1023, 1023, 4095);
        load_table(COUNT_W'(2), ents, 7'h03);
        queue_gid(24'h7FFFFF);
        queue_gid(24'h800FFE);
        queue_gid(24'hFFFFFF);
        drain_results();

        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_IDS)
        begin
            rn = $urandom_range(0, 9);
            cnt = (rn == 0) ? COUNT_W'(0) : (rn < 3) ? COUNT_W'(7) : COUNT_W'($urandom_range(1, 7));
            mask = (first_phase || $urandom_range(0, 3) != 0) ? '1 : MAX_SETS'($urandom);
            first_phase = 1'b0;
            unsorted = ($urandom_range(0, 7) == 0);
            step_max = 1 << (4 + 6 * $urandom_range(0, 3));
            prev = 0;
            for (int i = 0; i < MAX_SETS; i++)
            begin
                if (mask[i])
                begin
                    if (unsorted)
                        first_id = $urandom_range(0, 24'hFFFFFF);
                    else
                        first_id = prev + $urandom_range(0, step_max);
                    if (first_id > 24'hFFFFFF)
                        first_id = 24'hFFFFFF;
                    rn = $urandom_range(0, 7);
                    w = (rn == 0) ? 0 : (rn == 1) ? 1023 : $urandom_range(0, 1023);
                    rn = $urandom_range(0, 7);
                    h = (rn == 0) ? 0 : (rn == 1) ? 1023 : $urandom_range(0, 1023);
                    rn = $urandom_range(0, 11);
                    if (rn == 0)
                        cols = 0;
                    else if (rn == 1)
                        cols = 1;
                    else if (rn == 2)
                        cols = 4095;
                    else if (rn < 7)
                        cols = $urandom_range(1, 16);
                    else
                        cols = $urandom_range(1, 4095);
                    if ($urandom_range(0, 29) == 0)
                        ents[i] = '1;
                    else
                        ents[i] = make_entry(first_id, w, h, cols);
                end
                prev = 32'(ents[i][FIRST_LSB +: ID_W]);
            end
            load_table(cnt, ents, mask);

            batch = $urandom_range(30, 70);
            repeat (batch)
            begin
                k = $urandom_range(0, (cnt == 0) ? MAX_SETS - 1 : int'(cnt) - 1);
                first_id = 32'(ents[k][FIRST_LSB +: ID_W]);
                span = 4 * ents[k][COLS_LSB +: COLS_W] + 16;
                rn = $urandom_range(0, 9);
                if (rn == 0)
                    gid = $urandom & 24'hFFFFFF;
                else if (rn == 1)
                    gid = (first_id == 0) ? 0 : first_id - 1;
                else if (rn == 2)
                    gid = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
                else
                    gid = first_id + $urandom_range(0, span);
                if (gid > 24'hFFFFFF)
                    gid = 24'hFFFFFF;
                queue_gid(ID_W'(gid));
                random_sent++;
            end
            drain_results();
        end

        // Anything arriving now would be a stray result.
        repeat (RESULT_LATENCY + 5) @(posedge clk);
        $display("Checked %0d lookups from %0d ids over %0d table settings.",
                 results_checked, ids_sent, table_settings);
        $display("Status mix: %0d matched, %0d below every first id, %0d zero columns.",
                 status_hits[ST_OK], status_hits[ST_BELOW], status_hits[ST_NO_COLS]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timed out with %0d lookups outstanding.", pending_rects.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
